// File: src/usbhid_pkg.sv
// Package with types, request codes and descriptor tables of the USB HID control endpoint.
`default_nettype none
package usbhid_pkg;

    localparam int PACKET_BYTES      = 8;
    localparam int DEF_MAX_SETUP_LEN = 127;
    localparam int ROM_DEPTH         = 191;

    typedef enum logic [2:0] {
        OP_SETUP     = 3'd0,
        OP_IN_EP0    = 3'd1,
        OP_OUT_EP0   = 3'd2,
        OP_IN_DONE1  = 3'd3,
        OP_IN_DONE2  = 3'd4,
        OP_BUS_RESET = 3'd5
    } op_e;

    localparam logic [1:0] HS_ACK   = 2'd0;
    localparam logic [1:0] HS_NAK   = 2'd1;
    localparam logic [1:0] HS_STALL = 2'd2;

    localparam logic [7:0] NO_REQUEST = 8'hFF;

    // Standard requests.
    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_GET_INTERFACE = 8'h0A;

    // HID class requests.
    localparam logic [7:0] HID_GET_REPORT   = 8'h01;
    localparam logic [7:0] HID_GET_IDLE     = 8'h02;
    localparam logic [7:0] HID_GET_PROTOCOL = 8'h03;
    localparam logic [7:0] HID_SET_REPORT   = 8'h09;
    localparam logic [7:0] HID_SET_IDLE     = 8'h0A;
    localparam logic [7:0] HID_SET_PROTOCOL = 8'h0B;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam logic [4:0] RCP_DEVICE   = 5'd0;
    localparam logic [4:0] RCP_ENDPOINT = 5'd2;

    localparam logic [7:0] EP1_IN  = 8'h81;
    localparam logic [7:0] EP2_IN  = 8'h82;
    localparam logic [7:0] EP2_OUT = 8'h02;
    localparam logic [7:0] EP1_OUT = 8'h01;

    localparam logic [1:0] SEL_DEVICE   = 2'd0;
    localparam logic [1:0] SEL_CONFIG   = 2'd1;
    localparam logic [1:0] SEL_KEYBOARD = 2'd2;
    localparam logic [1:0] SEL_MOUSE    = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] setup_rx_len;
        logic [7:0] request_type;
        logic [7:0] request_code;
        logic [7:0] value_low;
        logic [7:0] value_high;
        logic [7:0] index_low;
        logic [7:0] index_high;
        logic [7:0] length_low;
        logic [7:0] length_high;
        logic [7:0] out_first_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  pending;
        logic [7:0]  rem;
        logic [1:0]  sel;
        logic [6:0]  off;
        logic [6:0]  addr;
        logic [7:0]  cfg;
        logic        conn;
        logic [7:0]  led;
        logic        led_new;
        logic [1:0]  ep1_in;
        logic [1:0]  ep2_in;
        logic        ep2_out_halt;
        logic [1:0]  ep0;
        logic [3:0]  tx_len;
        logic [63:0] tx_data;
    } state_t;

    localparam logic [7:0] DESC_ROM [0:ROM_DEPTH-1] = '{
        8'h12,8'h01,8'h10,8'h01,8'h00,8'h00,8'h00,8'h08,8'h3d,8'h41,8'h07,8'h21,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h01,
        8'h09,8'h02,8'h3b,8'h00,8'h02,8'h01,8'h00,8'hA0,8'h32,8'h09,8'h04,8'h00,8'h00,8'h01,
        8'h03,8'h01,8'h01,8'h00,
        8'h09,8'h21,8'h11,8'h01,8'h00,8'h01,8'h22,8'h3e,8'h00,8'h07,8'h05,8'h81,8'h03,8'h08,
        8'h00,8'h0a,
        8'h09,8'h04,8'h01,8'h00,8'h01,8'h03,8'h01,8'h02,8'h00,8'h09,8'h21,8'h10,8'h01,8'h00,
        8'h01,8'h22,8'h34,8'h00,
        8'h07,8'h05,8'h82,8'h03,8'h04,8'h00,8'h0a,
        8'h05,8'h01,8'h09,8'h06,8'hA1,8'h01,8'h05,8'h07,8'h19,8'he0,8'h29,8'he7,8'h15,8'h00,
        8'h25,8'h01,
        8'h75,8'h01,8'h95,8'h08,8'h81,8'h02,8'h95,8'h01,8'h75,8'h08,8'h81,8'h01,8'h95,8'h03,
        8'h75,8'h01,
        8'h05,8'h08,8'h19,8'h01,8'h29,8'h03,8'h91,8'h02,8'h95,8'h05,8'h75,8'h01,8'h91,8'h01,
        8'h95,8'h06,
        8'h75,8'h08,8'h26,8'hff,8'h00,8'h05,8'h07,8'h19,8'h00,8'h29,8'h91,8'h81,8'h00,8'hC0,
        8'h05,8'h01,8'h09,8'h02,8'hA1,8'h01,8'h09,8'h01,8'hA1,8'h00,8'h05,8'h09,8'h19,8'h01,
        8'h29,8'h03,
        8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h03,8'h81,8'h02,8'h75,8'h05,8'h95,8'h01,
        8'h81,8'h01,
        8'h05,8'h01,8'h09,8'h30,8'h09,8'h31,8'h09,8'h38,8'h15,8'h81,8'h25,8'h7f,8'h75,8'h08,
        8'h95,8'h03,
        8'h81,8'h06,8'hC0,8'hC0
    };

    function automatic logic [7:0] desc_base(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            SEL_DEVICE:   b = 8'd0;
            SEL_CONFIG:   b = 8'd18;
            SEL_KEYBOARD: b = 8'd77;
            default:      b = 8'd139;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] desc_size(input logic [1:0] sel);
        logic [7:0] s;
        case (sel)
            SEL_DEVICE:   s = 8'd18;
            SEL_CONFIG:   s = 8'd59;
            SEL_KEYBOARD: s = 8'd62;
            default:      s = 8'd52;
        endcase
        return s;
    endfunction

    // Bytes past the end of the selected descriptor read as zero.
    function automatic logic [7:0] rom_byte(input logic [1:0] sel, input logic [7:0] off);
        logic [7:0] idx;
        logic [7:0] b;
        idx = desc_base(sel) + off;
        if (off >= desc_size(sel)) b = 8'h00;
        else                       b = DESC_ROM[idx];
        return b;
    endfunction

endpackage
`default_nettype wire

// File: src/usbhid_step.sv
// Request decoder: next endpoint and device state for one transaction event.
`default_nettype none
module usbhid_step #(
    parameter int MAX_SETUP_LEN = usbhid_pkg::DEF_MAX_SETUP_LEN
) (
    input  usbhid_pkg::item_t  item,
    input  usbhid_pkg::state_t cur,
    output usbhid_pkg::state_t nxt
);
    import usbhid_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_SETUP_LEN);

    logic [7:0]  rem0;
    logic [7:0]  rem1;
    logic [4:0]  recip;
    logic [15:0] wvalue;
    logic [15:0] windex;
    logic        desc_ok;
    logic [1:0]  dsel;
    logic [7:0]  dsize;
    logic        is_setup;
    logic [1:0]  ch_sel;
    logic [6:0]  ch_off;
    logic [7:0]  ch_rem;
    logic [3:0]  ch_n;
    logic [63:0] ch_data;
    logic [7:0]  ch_idx [PACKET_BYTES];
    logic        ok;

    assign recip  = item.request_type[4:0];
    assign wvalue = {item.value_high, item.value_low};
    assign windex = {item.index_high, item.index_low};
    assign rem0   = (item.length_high != 8'd0 || item.length_low > MAX_LEN) ?
                    MAX_LEN : item.length_low;

    always_comb begin
        desc_ok = 1'b1;
        dsel    = SEL_DEVICE;
        unique case (item.value_high)
            DT_DEVICE: dsel = SEL_DEVICE;
            DT_CONFIG: dsel = SEL_CONFIG;
            DT_REPORT: begin
                if (item.index_low == 8'd0)      dsel = SEL_KEYBOARD;
                else if (item.index_low == 8'd1) dsel = SEL_MOUSE;
                else                             desc_ok = 1'b0;
            end
            default: desc_ok = 1'b0;
        endcase
    end

    assign dsize = desc_size(dsel);
    assign rem1  = (rem0 > dsize) ? dsize : rem0;

    // One chunk reader serves both the first chunk of a setup and later IN tokens.
    assign is_setup = (item.op == OP_SETUP);
    assign ch_sel   = is_setup ? dsel : cur.sel;
    assign ch_off   = is_setup ? 7'd0 : cur.off;
    assign ch_rem   = is_setup ? rem1 : cur.rem;
    assign ch_n     = (ch_rem >= 8'(PACKET_BYTES)) ? 4'(PACKET_BYTES) : ch_rem[3:0];

    always_comb begin
        ch_data = '0;
        for (int i = 0; i < PACKET_BYTES; i++) begin
            ch_idx[i] = {1'b0, ch_off} + 8'(i);
            if (4'(i) < ch_n) ch_data[8*i +: 8] = rom_byte(ch_sel, ch_idx[i]);
        end
    end

    always_comb begin
        nxt         = cur;
        nxt.led_new = 1'b0;
        ok          = 1'b1;
        case (item.op)
            OP_SETUP: begin
                nxt.tx_len  = '0;
                nxt.tx_data = '0;
                if (item.setup_rx_len != 7'd8) begin
                    ok = 1'b0;
                end else begin
                    nxt.rem     = rem0;
                    nxt.pending = item.request_code;
                    if (item.request_type[6:5] != 2'b00) begin
                        case (item.request_code) inside
                            HID_GET_REPORT, HID_GET_IDLE, HID_GET_PROTOCOL,
                            HID_SET_REPORT, HID_SET_IDLE, HID_SET_PROTOCOL: ok = 1'b1;
                            default: ok = 1'b0;
                        endcase
                    end else begin
                        unique case (item.request_code)
                            REQ_GET_DESC: begin
                                if (desc_ok) begin
                                    if (dsel == SEL_MOUSE) nxt.conn = 1'b1;
                                    nxt.sel     = dsel;
                                    nxt.tx_len  = ch_n;
                                    nxt.tx_data = ch_data;
                                    nxt.rem     = rem1 - {4'd0, ch_n};
                                    nxt.off     = {3'd0, ch_n};
                                end else begin
                                    ok = 1'b0;
                                end
                            end
                            REQ_SET_ADDRESS: nxt.rem = item.value_low;
                            REQ_GET_CONFIG: begin
                                if (rem0 != 8'd0) begin
                                    nxt.tx_len  = 4'd1;
                                    nxt.tx_data = {56'd0, cur.cfg};
                                end
                            end
                            REQ_SET_CONFIG:    nxt.cfg = item.value_low;
                            REQ_GET_INTERFACE: ok = 1'b1;
                            REQ_CLEAR_FEATURE: begin
                                if (recip == RCP_DEVICE) begin
                                    ok = 1'b1;
                                end else if (recip != RCP_ENDPOINT) begin
                                    ok = 1'b0;
                                end else begin
                                    unique case (item.index_low)
                                        EP2_IN:  nxt.ep2_in = HS_NAK;
                                        EP1_IN:  nxt.ep1_in = HS_NAK;
                                        EP2_OUT: nxt.ep2_out_halt = 1'b0;
                                        EP1_OUT: ok = 1'b1;
                                        default: ok = 1'b0;
                                    endcase
                                end
                            end
                            REQ_SET_FEATURE: begin
                                if (recip == RCP_DEVICE) begin
                                    ok = (wvalue == 16'd1);
                                end else if (recip != RCP_ENDPOINT || wvalue != 16'd0) begin
                                    ok = 1'b0;
                                end else begin
                                    unique case (windex)
                                        {8'd0, EP2_IN}:  nxt.ep2_in = HS_STALL;
                                        {8'd0, EP2_OUT}: nxt.ep2_out_halt = 1'b1;
                                        {8'd0, EP1_IN}:  nxt.ep1_in = HS_STALL;
                                        default:         ok = 1'b0;
                                    endcase
                                end
                            end
                            REQ_GET_STATUS: begin
                                nxt.tx_len = (rem0 >= 8'd2) ? 4'd2 : rem0[3:0];
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                end
                if (ok) begin
                    nxt.ep0 = HS_ACK;
                end else begin
                    nxt.pending = NO_REQUEST;
                    nxt.ep0     = HS_STALL;
                    nxt.tx_len  = '0;
                    nxt.tx_data = '0;
                end
            end
            OP_IN_EP0: begin
                if (cur.pending == REQ_GET_DESC) begin
                    nxt.tx_len  = ch_n;
                    nxt.tx_data = ch_data;
                    nxt.rem     = cur.rem - {4'd0, ch_n};
                    nxt.off     = cur.off + {3'd0, ch_n};
                end else begin
                    if (cur.pending == REQ_SET_ADDRESS) nxt.addr = cur.rem[6:0];
                    nxt.ep0     = HS_NAK;
                    nxt.tx_len  = '0;
                    nxt.tx_data = '0;
                end
            end
            OP_OUT_EP0: begin
                if (item.setup_rx_len != 7'd0) begin
                    nxt.led     = item.out_first_byte;
                    nxt.led_new = 1'b1;
                end
            end
            OP_IN_DONE1: nxt.ep1_in = HS_NAK;
            OP_IN_DONE2: nxt.ep2_in = HS_NAK;
            OP_BUS_RESET: begin
                nxt.ep0          = HS_NAK;
                nxt.ep1_in       = HS_NAK;
                nxt.ep2_in       = HS_NAK;
                nxt.ep2_out_halt = 1'b0;
                nxt.addr         = '0;
                nxt.tx_len       = '0;
                nxt.tx_data      = '0;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: src/usb_hid_control_endpoint_top.sv
// Top level of the USB HID control endpoint: request register, decoder and result register.
// A request accepted into the request register is decoded combinationally, and its result
// is registered onto the m_ ports when the result slot is empty or being drained.
// Throughput: one request per cycle while m_ready is high; the input register and result
// register each take one new request whenever the stage after them moves.
// Reset (aresetn low, synchronous) empties both stages, clears address, configuration,
// LED byte and connected flag, sets ep0, ep1 in and ep2 in to nak and forgets any request.
`default_nettype none
module usb_hid_control_endpoint_top #(
    parameter int MAX_SETUP_LEN = usbhid_pkg::DEF_MAX_SETUP_LEN
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [6:0]  s_setup_rx_len,
    input  wire logic [7:0]  s_request_type,
    input  wire logic [7:0]  s_request_code,
    input  wire logic [7:0]  s_value_low,
    input  wire logic [7:0]  s_value_high,
    input  wire logic [7:0]  s_index_low,
    input  wire logic [7:0]  s_index_high,
    input  wire logic [7:0]  s_length_low,
    input  wire logic [7:0]  s_length_high,
    input  wire logic [7:0]  s_out_first_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_ep0_response,
    output logic [3:0]       m_tx_len,
    output logic [63:0]      m_tx_data,
    output logic [6:0]       m_device_address,
    output logic [7:0]       m_config_value,
    output logic             m_connected,
    output logic [7:0]       m_led_bits,
    output logic             m_led_new,
    output logic [1:0]       m_ep1_in_state,
    output logic [1:0]       m_ep2_in_state,
    output logic             m_ep2_out_stalled
);
    import usbhid_pkg::*;

    // The device state doubles as the result register: it only changes when the
    // result slot is free or being taken, so a stalled result holds steady.
    localparam state_t STATE_RESET = '{
        pending: NO_REQUEST, rem: '0, sel: SEL_DEVICE, off: '0, addr: '0, cfg: '0,
        conn: 1'b0, led: '0, led_new: 1'b0, ep1_in: HS_NAK, ep2_in: HS_NAK,
        ep2_out_halt: 1'b0, ep0: HS_NAK, tx_len: '0, tx_data: '0
    };

    logic   in_valid_reg;
    item_t  item_reg;
    logic   out_valid_reg;
    state_t state_reg;
    state_t state_next;
    logic   advance;

    // The decode stage moves whenever the result slot is empty or being drained.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{op: s_op, setup_rx_len: s_setup_rx_len,
                          request_type: s_request_type, request_code: s_request_code,
                          value_low: s_value_low, value_high: s_value_high,
                          index_low: s_index_low, index_high: s_index_high,
                          length_low: s_length_low, length_high: s_length_high,
                          out_first_byte: s_out_first_byte};
        end
    end

    usbhid_step #(
        .MAX_SETUP_LEN(MAX_SETUP_LEN)
    ) u_step (
        .item(item_reg),
        .cur (state_reg),
        .nxt (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) state_reg <= state_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_ep0_response    = state_reg.ep0;
    assign m_tx_len          = state_reg.tx_len;
    assign m_tx_data         = state_reg.tx_data;
    assign m_device_address  = state_reg.addr;
    assign m_config_value    = state_reg.cfg;
    assign m_connected       = state_reg.conn;
    assign m_led_bits        = state_reg.led;
    assign m_led_new         = state_reg.led_new;
    assign m_ep1_in_state    = state_reg.ep1_in;
    assign m_ep2_in_state    = state_reg.ep2_in;
    assign m_ep2_out_stalled = state_reg.ep2_out_halt;

endmodule
`default_nettype wire

// File: src/usbhid_checker.sv
// Port-level checks of the USB HID control endpoint and the bind that attaches them.
`default_nettype none
module usbhid_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_ep0_response,
    input wire logic [3:0]  m_tx_len,
    input wire logic [63:0] m_tx_data,
    input wire logic        m_connected
);
    import usbhid_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_data) && $stable(m_tx_len))
        else $error("result changed while stalled");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tx_len <= 4'(PACKET_BYTES))
        else $error("tx length above packet size");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ep0_response == HS_STALL |-> m_tx_len == 4'd0 && m_tx_data == 64'd0)
        else $error("stalled ep0 with data armed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_len == 4'd0 |-> m_tx_data == 64'd0)
        else $error("data armed with zero length");

    a_conn: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_connected) && $past(aresetn) |-> m_connected)
        else $error("connected flag dropped without reset");

endmodule

bind usb_hid_control_endpoint_top usbhid_checker u_usbhid_checker (.*);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the USB HID control endpoint top level.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import usbhid_pkg::*;

    // Fields of one armed result, in the order the block reports them.
    typedef struct packed {
        logic [1:0]  ep0;
        logic [3:0]  tx_len;
        logic [63:0] tx_data;
        logic [6:0]  addr;
        logic [7:0]  cfg;
        logic        conn;
        logic [7:0]  led;
        logic        led_new;
        logic [1:0]  ep1_in;
        logic [1:0]  ep2_in;
        logic        ep2_out_halt;
    } response_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_BITS      = $bits(item_t);

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    item_t       req;
    logic        m_valid;
    logic        m_ready;
    response_t   got;

    // Device state as the checker sees it, updated once per accepted request.
    logic [7:0]  dev_pending;
    logic [7:0]  dev_remaining;
    logic [1:0]  dev_select;
    logic [6:0]  dev_offset;
    logic [6:0]  dev_address;
    logic [7:0]  dev_config;
    logic        dev_connected;
    logic [7:0]  dev_led;
    logic [1:0]  dev_ep1_in;
    logic [1:0]  dev_ep2_in;
    logic [1:0]  dev_ep2_out;
    logic [1:0]  dev_ep0;
    logic [3:0]  dev_tx_len;
    logic [63:0] dev_tx_data;

    response_t   expected_responses[$];
    int          error_count;
    int          requests_sent;
    int          responses_checked;
    int          idle_cycles;
    int          chunks_seen;
    bit          no_idle;

    usb_hid_control_endpoint_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (req.op),
        .s_setup_rx_len    (req.setup_rx_len),
        .s_request_type    (req.request_type),
        .s_request_code    (req.request_code),
        .s_value_low       (req.value_low),
        .s_value_high      (req.value_high),
        .s_index_low       (req.index_low),
        .s_index_high      (req.index_high),
        .s_length_low      (req.length_low),
        .s_length_high     (req.length_high),
        .s_out_first_byte  (req.out_first_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ep0_response    (got.ep0),
        .m_tx_len          (got.tx_len),
        .m_tx_data         (got.tx_data),
        .m_device_address  (got.addr),
        .m_config_value    (got.cfg),
        .m_connected       (got.conn),
        .m_led_bits        (got.led),
        .m_led_new         (got.led_new),
        .m_ep1_in_state    (got.ep1_in),
        .m_ep2_in_state    (got.ep2_in),
        .m_ep2_out_stalled (got.ep2_out_halt)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Descriptor byte lookup: the table layout is kept here independently of the package
    // helpers, only the ROM contents are shared.
    function automatic logic [7:0] descriptor_byte(input logic [1:0] which, input int pos);
        int base;
        int size;
        case (which)
            SEL_DEVICE:   begin base = 0;   size = 18; end
            SEL_CONFIG:   begin base = 18;  size = 59; end
            SEL_KEYBOARD: begin base = 77;  size = 62; end
            default:      begin base = 139; size = 52; end
        endcase
        if (pos >= size) return 8'h00;
        return DESC_ROM[base + pos];
    endfunction

    function automatic logic [7:0] descriptor_size(input logic [1:0] which);
        case (which)
            SEL_DEVICE:   return 8'd18;
            SEL_CONFIG:   return 8'd59;
            SEL_KEYBOARD: return 8'd62;
            default:      return 8'd52;
        endcase
    endfunction

    function automatic void device_reset();
        dev_pending   = NO_REQUEST;
        dev_remaining = '0;
        dev_select    = '0;
        dev_offset    = '0;
        dev_address   = '0;
        dev_config    = '0;
        dev_connected = 1'b0;
        dev_led       = '0;
        dev_ep1_in    = HS_NAK;
        dev_ep2_in    = HS_NAK;
        dev_ep2_out   = HS_ACK;
        dev_ep0       = HS_NAK;
        dev_tx_len    = '0;
        dev_tx_data   = '0;
    endfunction

    // Arms the next descriptor chunk of up to one packet.
    function automatic void arm_descriptor_chunk();
        int n;
        n = (dev_remaining >= PACKET_BYTES) ? PACKET_BYTES : int'(dev_remaining);
        dev_tx_data = '0;
        for (int i = 0; i < n; i++)
            dev_tx_data[8*i +: 8] = descriptor_byte(dev_select, int'(dev_offset) + i);
        dev_tx_len    = 4'(n);
        dev_remaining = dev_remaining - 8'(n);
        dev_offset    = dev_offset + 7'(n);
        chunks_seen++;
    endfunction

    function automatic bit decode_standard(input item_t r);
        logic [4:0]  recip;
        logic [15:0] wvalue;
        logic [15:0] windex;
        logic [7:0]  dtype;
        recip  = r.request_type[4:0];
        wvalue = {r.value_high, r.value_low};
        windex = {r.index_high, r.index_low};
        case (r.request_code)
            REQ_GET_DESC: begin
                dtype = r.value_high;
                if (dtype == DT_DEVICE) dev_select = SEL_DEVICE;
                else if (dtype == DT_CONFIG) dev_select = SEL_CONFIG;
                else if (dtype == DT_REPORT && r.index_low == 8'd0) dev_select = SEL_KEYBOARD;
                else if (dtype == DT_REPORT && r.index_low == 8'd1) begin
                    dev_select    = SEL_MOUSE;
                    dev_connected = 1'b1;
                end else return 1'b0;
                dev_offset = '0;
                if (dev_remaining > descriptor_size(dev_select))
                    dev_remaining = descriptor_size(dev_select);
                arm_descriptor_chunk();
                return 1'b1;
            end
            REQ_SET_ADDRESS: begin
                dev_remaining = r.value_low;
                return 1'b1;
            end
            REQ_GET_CONFIG: begin
                if (dev_remaining >= 1) begin
                    dev_tx_len  = 4'd1;
                    dev_tx_data = {56'd0, dev_config};
                end
                return 1'b1;
            end
            REQ_SET_CONFIG: begin
                dev_config = r.value_low;
                return 1'b1;
            end
            REQ_GET_INTERFACE: return 1'b1;
            REQ_CLEAR_FEATURE: begin
                if (recip == RCP_DEVICE) return 1'b1;
                if (recip != RCP_ENDPOINT) return 1'b0;
                case (r.index_low)
                    EP2_IN:  dev_ep2_in  = HS_NAK;
                    EP1_IN:  dev_ep1_in  = HS_NAK;
                    EP2_OUT: dev_ep2_out = HS_ACK;
                    EP1_OUT: ;
                    default: return 1'b0;
                endcase
                return 1'b1;
            end
            REQ_SET_FEATURE: begin
                if (recip == RCP_DEVICE) return wvalue == 16'd1;
                if (recip != RCP_ENDPOINT || wvalue != 16'd0) return 1'b0;
                if (windex == {8'd0, EP2_IN}) dev_ep2_in = HS_STALL;
                else if (windex == {8'd0, EP2_OUT}) dev_ep2_out = HS_STALL;
                else if (windex == {8'd0, EP1_IN}) dev_ep1_in = HS_STALL;
                else return 1'b0;
                return 1'b1;
            end
            REQ_GET_STATUS: begin
                dev_tx_len = (dev_remaining >= 2) ? 4'd2 : 4'(dev_remaining);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Advances the device state by one request and returns the response it arms.
    function automatic response_t predict_response(input item_t r);
        response_t resp;
        bit        accepted;
        bit        led_latched;
        led_latched = 1'b0;
        case (r.op)
            OP_SETUP: begin
                dev_tx_len  = '0;
                dev_tx_data = '0;
                if (r.setup_rx_len != 7'd8) begin
                    accepted = 1'b0;
                end else begin
                    dev_remaining = r.length_low;
                    if (r.length_high != 0 || r.length_low > DEF_MAX_SETUP_LEN)
                        dev_remaining = 8'(DEF_MAX_SETUP_LEN);
                    dev_pending = r.request_code;
                    if (r.request_type[6:5] != 2'b00)
                        accepted = r.request_code inside {HID_GET_REPORT, HID_GET_IDLE,
                            HID_GET_PROTOCOL, HID_SET_REPORT, HID_SET_IDLE, HID_SET_PROTOCOL};
                    else
                        accepted = decode_standard(r);
                end
                if (accepted) begin
                    dev_ep0 = HS_ACK;
                end else begin
                    dev_pending = NO_REQUEST;
                    dev_ep0     = HS_STALL;
                    dev_tx_len  = '0;
                    dev_tx_data = '0;
                end
            end
            OP_IN_EP0: begin
                if (dev_pending == REQ_GET_DESC) begin
                    arm_descriptor_chunk();
                end else begin
                    if (dev_pending == REQ_SET_ADDRESS) dev_address = dev_remaining[6:0];
                    dev_ep0     = HS_NAK;
                    dev_tx_len  = '0;
                    dev_tx_data = '0;
                end
            end
            OP_OUT_EP0: begin
                if (r.setup_rx_len != 0) begin
                    dev_led     = r.out_first_byte;
                    led_latched = 1'b1;
                end
            end
            OP_IN_DONE1: dev_ep1_in = HS_NAK;
            OP_IN_DONE2: dev_ep2_in = HS_NAK;
            OP_BUS_RESET: begin
                dev_ep0     = HS_NAK;
                dev_ep1_in  = HS_NAK;
                dev_ep2_in  = HS_NAK;
                dev_ep2_out = HS_ACK;
                dev_address = '0;
                dev_tx_len  = '0;
                dev_tx_data = '0;
            end
            default: ;
        endcase
        resp.ep0          = dev_ep0;
        resp.tx_len       = dev_tx_len;
        resp.tx_data      = dev_tx_data;
        resp.addr         = dev_address;
        resp.cfg          = dev_config;
        resp.conn         = dev_connected;
        resp.led          = dev_led;
        resp.led_new      = led_latched;
        resp.ep1_in       = dev_ep1_in;
        resp.ep2_in       = dev_ep2_in;
        resp.ep2_out_halt = (dev_ep2_out == HS_STALL);
        return resp;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] want);
        $display("MISMATCH response %0d %s: got %0h expected %0h",
                 responses_checked, what, seen, want);
        error_count++;
    endtask

    // Drives one request and holds it until the block takes it. The prediction is made
    // when the request is accepted, so the state follows the acceptance order. Valid is
    // only dropped when the sender idles, so back-to-back requests leave it high.
    task automatic send_request(input item_t r);
        while (!no_idle && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        req     <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_responses.push_back(predict_response(r));
        requests_sent++;
        @(negedge aclk);
    endtask

    // Receiver: stalls at random, then compares each accepted response field by field.
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        response_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                $display("MISMATCH unexpected response with nothing outstanding");
                error_count++;
            end else begin
                want = expected_responses.pop_front();
                if (got.ep0 !== want.ep0)
                    report_mismatch("ep0_response", 64'(got.ep0), 64'(want.ep0));
                if (got.tx_len !== want.tx_len)
                    report_mismatch("tx_len", 64'(got.tx_len), 64'(want.tx_len));
                if (got.tx_data !== want.tx_data)
                    report_mismatch("tx_data", got.tx_data, want.tx_data);
                if (got.addr !== want.addr)
                    report_mismatch("device_address", 64'(got.addr), 64'(want.addr));
                if (got.cfg !== want.cfg)
                    report_mismatch("config_value", 64'(got.cfg), 64'(want.cfg));
                if (got.conn !== want.conn)
                    report_mismatch("connected", 64'(got.conn), 64'(want.conn));
                if (got.led !== want.led)
                    report_mismatch("led_bits", 64'(got.led), 64'(want.led));
                if (got.led_new !== want.led_new)
                    report_mismatch("led_new", 64'(got.led_new), 64'(want.led_new));
                if (got.ep1_in !== want.ep1_in)
                    report_mismatch("ep1_in_state", 64'(got.ep1_in), 64'(want.ep1_in));
                if (got.ep2_in !== want.ep2_in)
                    report_mismatch("ep2_in_state", 64'(got.ep2_in), 64'(want.ep2_in));
                if (got.ep2_out_halt !== want.ep2_out_halt)
                    report_mismatch("ep2_out_stalled", 64'(got.ep2_out_halt),
                                    64'(want.ep2_out_halt));
            end
            responses_checked++;
        end
    end

    // Watchdog: any cycle with no handshake on either side counts toward the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d responses outstanding",
                     expected_responses.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Builders for the request shapes used by the tests.
    function automatic item_t make_setup(input logic [7:0] rtype, input logic [7:0] code,
                                         input logic [15:0] wvalue, input logic [15:0] windex,
                                         input logic [15:0] wlength);
        item_t r;
        r              = item_t'(ITEM_BITS'({$urandom, $urandom, $urandom}));
        r.op           = OP_SETUP;
        r.setup_rx_len = 7'd8;
        r.request_type = rtype;
        r.request_code = code;
        {r.value_high, r.value_low}   = wvalue;
        {r.index_high, r.index_low}   = windex;
        {r.length_high, r.length_low} = wlength;
        return r;
    endfunction

    function automatic item_t make_op(input op_e op);
        item_t r;
        r    = item_t'(ITEM_BITS'({$urandom, $urandom, $urandom}));
        r.op = op;
        return r;
    endfunction

    // Random request: random fields, every op code incl. unused; setup_rx_len mostly 0-64.
    function automatic item_t make_noise();
        item_t r;
        r = item_t'(ITEM_BITS'({$urandom, $urandom, $urandom}));
        if ($urandom_range(3) != 0) r.setup_rx_len = 7'($urandom_range(64));
        return r;
    endfunction

    // Walks a descriptor read through all of its IN stages.
    task automatic read_descriptor(input logic [7:0] dtype, input logic [7:0] index,
                                   input logic [15:0] wlength);
        send_request(make_setup(8'h80, REQ_GET_DESC, {dtype, 8'h00}, {8'h00, index}, wlength));
        for (int i = 0; i < 17; i++) send_request(make_op(OP_IN_EP0));
    endtask

    task automatic test_enumeration();
        item_t r;
        read_descriptor(DT_DEVICE, 8'h00, 16'd64);
        send_request(make_setup(8'h00, REQ_SET_ADDRESS, 16'h007F, 16'h0000, 16'h0000));
        send_request(make_op(OP_IN_EP0));
        read_descriptor(DT_CONFIG, 8'h00, 16'hFFFF);
        send_request(make_setup(8'h00, REQ_SET_CONFIG, 16'h00FF, 16'h0000, 16'h0000));
        send_request(make_setup(8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001));
        send_request(make_setup(8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002));
        send_request(make_setup(8'h80, REQ_GET_INTERFACE, 16'h0000, 16'h0000, 16'h0001));
        read_descriptor(DT_REPORT, 8'h00, 16'd200);
        read_descriptor(DT_REPORT, 8'h01, 16'd127);
        r = make_op(OP_OUT_EP0);
        r.setup_rx_len   = 7'd1;
        r.out_first_byte = 8'hFF;
        send_request(r);
    endtask

    task automatic test_special_cases();
        item_t r;
        r = make_setup(8'h80, REQ_GET_DESC, 16'h0100, 16'h0000, 16'd18);
        r.setup_rx_len = 7'd64;
        send_request(r);
        send_request(make_setup(8'h80, REQ_GET_DESC, 16'h0300, 16'h0000, 16'd8));
        send_request(make_setup(8'h81, REQ_GET_DESC, 16'h2200, 16'h0002, 16'd8));
        send_request(make_setup(8'h21, HID_SET_IDLE, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_setup(8'hA1, 8'h04, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_setup(8'h02, REQ_SET_FEATURE, 16'h0000, {8'h00, EP1_IN}, 16'h0));
        send_request(make_setup(8'h02, REQ_SET_FEATURE, 16'h0000, {8'h00, EP2_IN}, 16'h0));
        send_request(make_setup(8'h02, REQ_SET_FEATURE, 16'h0000, {8'h00, EP2_OUT}, 16'h0));
        send_request(make_setup(8'h02, REQ_CLEAR_FEATURE, 16'h0000, {8'h00, EP2_OUT}, 16'h0));
        send_request(make_setup(8'h02, REQ_CLEAR_FEATURE, 16'h0000, {8'h00, EP1_IN}, 16'h0));
        send_request(make_setup(8'h02, REQ_CLEAR_FEATURE, 16'h0000, {8'h00, EP1_OUT}, 16'h0));
        send_request(make_setup(8'h02, REQ_CLEAR_FEATURE, 16'h0000, 16'h0005, 16'h0));
        send_request(make_setup(8'h01, REQ_CLEAR_FEATURE, 16'h0000, 16'h0000, 16'h0));
        send_request(make_setup(8'h00, REQ_SET_FEATURE, 16'h0001, 16'h0000, 16'h0));
        send_request(make_op(OP_IN_DONE2));
        send_request(make_op(OP_IN_DONE1));
        r = make_op(OP_OUT_EP0);
        r.setup_rx_len = 7'd0;
        send_request(r);
        send_request(make_op(OP_BUS_RESET));
        r = make_op(OP_BUS_RESET);
        r.op = 3'd7;
        send_request(r);
    endtask

    // Random part: control setups with random content, IN tokens, other ops and noise.
    task automatic test_random_traffic(input int count);
        logic [7:0] codes[10];
        item_t      r;
        int         choice;
        codes = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_ADDRESS,
                  REQ_GET_DESC, REQ_GET_CONFIG, REQ_SET_CONFIG, REQ_GET_INTERFACE,
                  HID_SET_PROTOCOL, 8'h0C};
        for (int n = 0; n < count; n++) begin
            no_idle = (n >= count / 2) && (n < count / 2 + 200);
            choice  = $urandom_range(99);
            if (choice < 20) begin
                r = make_noise();
            end else if (choice < 70) begin
                r = make_setup($urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(2)),
                               codes[$urandom_range(9)], 16'($urandom_range(3)) |
                               ($urandom_range(1) ? 16'h2200 : 16'($urandom) & 16'h03FF),
                               $urandom_range(1) ? {8'h00, EP1_IN} : 16'($urandom),
                               16'($urandom_range(1) ? $urandom_range(140) : $urandom));
                if ($urandom_range(1)) r.value_high = $urandom_range(1) ? DT_REPORT : 8'd1;
                if ($urandom_range(1)) r.index_low = 8'($urandom_range(2));
            end else if (choice < 90) begin
                r = make_op(OP_IN_EP0);
            end else begin
                r = make_op(op_e'($urandom_range(5)));
            end
            send_request(r);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        req               = '0;
        error_count       = 0;
        requests_sent     = 0;
        responses_checked = 0;
        idle_cycles       = 0;
        chunks_seen       = 0;
        no_idle           = 1'b0;
        device_reset();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_enumeration();
        test_special_cases();
        test_random_traffic(2000);
        s_valid <= 1'b0;

        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d requests and checked %0d responses, %0d descriptor chunks.",
                 requests_sent, responses_checked, chunks_seen);
        $display("Covered enumeration, feature handling, class requests and bus resets.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
src/usbhid_pkg.sv
src/usbhid_step.sv
src/usb_hid_control_endpoint_top.sv
src/usbhid_checker.sv
tb/tb.sv
